// ===== hw/rtl/nfpl_pkg.sv =====
// ----------------------------------------------------------------------------
// nfpl_pkg
// Shared codes, constants and types of the NOR flash model with power loss.
// ----------------------------------------------------------------------------
package nfpl_pkg;

    localparam int MEMORY_BYTES_DEF = 65536;
    localparam int MAX_UNIT_BYTES   = 8;
    localparam int TOTAL_W          = 48;

    localparam logic [7:0] ERASED_BYTE = 8'hFF;

    localparam logic [2:0] OP_READ    = 3'd0;
    localparam logic [2:0] OP_PROGRAM = 3'd1;
    localparam logic [2:0] OP_ERASE   = 3'd2;
    localparam logic [2:0] OP_ARM     = 3'd3;
    localparam logic [2:0] OP_DISARM  = 3'd4;
    localparam logic [2:0] OP_RESTORE = 3'd5;

    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_GEOMETRY   = 3'd1;
    localparam logic [2:0] ST_RANGE      = 3'd2;
    localparam logic [2:0] ST_UNALIGNED  = 3'd3;
    localparam logic [2:0] ST_TRANSITION = 3'd4;
    localparam logic [2:0] ST_POWER      = 3'd5;

    localparam logic [1:0] CFG_SECTOR_COUNT = 2'd0;
    localparam logic [1:0] CFG_SECTOR_LOG2  = 2'd1;
    localparam logic [1:0] CFG_UNIT_LOG2    = 2'd2;

    typedef struct packed {
        logic               ok;
        logic [TOTAL_W-1:0] total;
        logic [1:0]         unit_log2;
        logic [4:0]         sector_log2;
    } geo_t;

    typedef struct packed {
        logic        persist;
        logic        arm;
        logic        disarm;
        logic        restore;
        logic [31:0] fail_after;
    } eff_cmd_t;

    typedef struct packed {
        logic        power_down;
        logic        blocked;
        logic        last;
        logic [31:0] total;
    } eff_sts_t;

endpackage

// ===== hw/rtl/nfpl_byte_mem.sv =====
// ----------------------------------------------------------------------------
// nfpl_byte_mem
// Byte-wide single-port store with a registered read, one write per cycle.
// ----------------------------------------------------------------------------
module nfpl_byte_mem
    import nfpl_pkg::*;
#(
    parameter int MEMORY_BYTES = MEMORY_BYTES_DEF,
    localparam int AW = $clog2(MEMORY_BYTES)
)
(
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] addr,
    input  logic [7:0]    wdata,
    output logic [7:0]    rdata
);

    logic [7:0] mem_array [MEMORY_BYTES];
    logic [7:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_array[addr] <= wdata;
        end
        rd_data_reg <= mem_array[addr];
    end

    assign rdata = rd_data_reg;

endmodule

// ===== hw/rtl/nfpl_effect_unit.sv =====
// ----------------------------------------------------------------------------
// nfpl_effect_unit
// Power-loss bookkeeping: armed failure countdown, sticky power-down flag and
// the saturating count of persisted bytes.
// ----------------------------------------------------------------------------
module nfpl_effect_unit
    import nfpl_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  eff_cmd_t cmd,
    output eff_sts_t sts
);

    logic        power_down_reg;
    logic        armed_reg;
    logic [31:0] left_reg;
    logic [31:0] total_reg;

    logic        blocked;
    logic        last;

    assign blocked = armed_reg && (left_reg == 32'd0);
    assign last    = armed_reg && (left_reg == 32'd1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            power_down_reg <= 1'b0;
            armed_reg      <= 1'b0;
            left_reg       <= 32'd0;
            total_reg      <= 32'd0;
        end
        else if (cmd.restore)
        begin
            power_down_reg <= 1'b0;
            armed_reg      <= 1'b0;
            left_reg       <= 32'd0;
            total_reg      <= 32'd0;
        end
        else if (cmd.arm)
        begin
            armed_reg <= 1'b1;
            left_reg  <= cmd.fail_after;
        end
        else if (cmd.disarm)
        begin
            armed_reg <= 1'b0;
            left_reg  <= 32'd0;
        end
        else if (cmd.persist)
        begin
            // A blocked byte writes nothing and only drops power.
            if (blocked)
            begin
                power_down_reg <= 1'b1;
            end
            else
            begin
                if (total_reg != 32'hFFFF_FFFF)
                begin
                    total_reg <= total_reg + 32'd1;
                end
                if (armed_reg)
                begin
                    left_reg <= left_reg - 32'd1;
                end
                if (last)
                begin
                    power_down_reg <= 1'b1;
                end
            end
        end
    end

    assign sts.power_down = power_down_reg;
    assign sts.blocked    = blocked;
    assign sts.last       = last;
    assign sts.total      = total_reg;

endmodule

// ===== hw/rtl/nfpl_ctrl.sv =====
// ----------------------------------------------------------------------------
// nfpl_ctrl
// Command sequencer: clearing pass, checks, single-byte read, program verify
// and write, sector erase over the byte store, and power-loss arm, disarm and restore.
// ----------------------------------------------------------------------------
module nfpl_ctrl
    import nfpl_pkg::*;
#(
    parameter int MEMORY_BYTES = MEMORY_BYTES_DEF,
    localparam int AW = $clog2(MEMORY_BYTES),
    localparam int WA = ((AW > 17) ? AW : 17) + 1
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  logic [2:0]    opcode,
    input  logic [16:0]   address,
    input  logic [63:0]   program_data,
    input  logic [31:0]   fail_after_count,
    input  geo_t          geo,
    output logic          done,
    output logic [2:0]    status,
    output logic [7:0]    read_data,
    output logic          mem_we,
    output logic [AW-1:0] mem_addr,
    output logic [7:0]    mem_wdata,
    input  logic [7:0]    mem_rdata,
    output eff_cmd_t      eff_cmd,
    input  eff_sts_t      eff_sts
);

    localparam logic [3:0] S_CLEAR  = 4'd0;
    localparam logic [3:0] S_IDLE   = 4'd1;
    localparam logic [3:0] S_DECODE = 4'd2;
    localparam logic [3:0] S_READ   = 4'd3;
    localparam logic [3:0] S_PRD    = 4'd4;
    localparam logic [3:0] S_PCMP   = 4'd5;
    localparam logic [3:0] S_PWR    = 4'd6;
    localparam logic [3:0] S_ERASE  = 4'd7;
    localparam logic [3:0] S_RESP   = 4'd8;

    localparam logic [AW-1:0] CLEAR_LAST = AW'(MEMORY_BYTES - 1);

    logic [3:0]    state_reg, state_next;
    logic [AW-1:0] off_reg, off_next;
    logic [AW-1:0] off_last_reg, off_last_next;
    logic [2:0]    status_reg, status_next;
    logic [7:0]    rdata_reg, rdata_next;

    logic [2:0]    op_reg;
    logic [16:0]   addr_reg;
    logic [63:0]   data_reg;
    logic [31:0]   fail_reg;

    logic               accept;
    logic [WA-1:0]      byte_addr;
    logic [7:0]         data_byte;
    logic [TOTAL_W-1:0] addr_w;
    logic [TOTAL_W-1:0] unit_w;
    logic [TOTAL_W-1:0] ssize_w;
    logic [TOTAL_W-1:0] unit_last_w;
    logic [TOTAL_W-1:0] sector_last_w;
    logic               read_range_bad;
    logic               prog_range_bad;
    logic               prog_unaligned;
    logic               erase_range_bad;
    logic               erase_unaligned;

    assign busy   = !((state_reg == S_IDLE) || (state_reg == S_RESP));
    assign accept = start && !busy;
    assign done   = (state_reg == S_RESP);

    assign byte_addr = WA'(addr_reg) + WA'(off_reg);
    assign mem_addr  = (state_reg == S_CLEAR) ? off_reg : byte_addr[AW-1:0];
    assign data_byte = data_reg[{off_reg[2:0], 3'b000} +: 8];

    assign addr_w        = TOTAL_W'(addr_reg);
    assign unit_w        = TOTAL_W'(1) << geo.unit_log2;
    assign ssize_w       = TOTAL_W'(1) << geo.sector_log2;
    assign unit_last_w   = unit_w - TOTAL_W'(1);
    assign sector_last_w = ssize_w - TOTAL_W'(1);

    assign read_range_bad  = addr_w >= geo.total;
    assign prog_range_bad  = (addr_w + unit_w) > geo.total;
    assign prog_unaligned  = (addr_w & unit_last_w) != '0;
    assign erase_range_bad = (addr_w + ssize_w) > geo.total;
    assign erase_unaligned = (addr_w & sector_last_w) != '0;

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg   <= opcode;
            addr_reg <= address;
            data_reg <= program_data;
            fail_reg <= fail_after_count;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_CLEAR;
            off_reg      <= '0;
            off_last_reg <= '0;
            status_reg   <= ST_OK;
            rdata_reg    <= 8'd0;
        end
        else
        begin
            state_reg    <= state_next;
            off_reg      <= off_next;
            off_last_reg <= off_last_next;
            status_reg   <= status_next;
            rdata_reg    <= rdata_next;
        end
    end

    always_comb
    begin
        state_next         = state_reg;
        off_next           = off_reg;
        off_last_next      = off_last_reg;
        status_next        = status_reg;
        rdata_next         = rdata_reg;
        mem_we             = 1'b0;
        mem_wdata          = data_byte;
        eff_cmd            = '0;
        eff_cmd.fail_after = fail_reg;

        case (state_reg)
            S_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_wdata = ERASED_BYTE;
                if (off_reg == CLEAR_LAST)
                begin
                    off_next   = '0;
                    state_next = S_IDLE;
                end
                else
                begin
                    off_next = off_reg + AW'(1);
                end
            end

            S_IDLE, S_RESP:
            begin
                state_next = accept ? S_DECODE : S_IDLE;
            end

            S_DECODE:
            begin
                rdata_next  = 8'd0;
                status_next = ST_OK;
                state_next  = S_RESP;
                if ((op_reg inside {OP_READ, OP_PROGRAM, OP_ERASE, OP_RESTORE}) && !geo.ok)
                begin
                    status_next = ST_GEOMETRY;
                end
                else if ((op_reg <= OP_DISARM) && eff_sts.power_down)
                begin
                    status_next = ST_POWER;
                end
                else
                begin
                    case (op_reg)
                        OP_READ:
                        begin
                            if (read_range_bad)
                            begin
                                status_next = ST_RANGE;
                            end
                            else
                            begin
                                state_next = S_READ;
                            end
                        end
                        OP_PROGRAM:
                        begin
                            if (prog_range_bad)
                            begin
                                status_next = ST_RANGE;
                            end
                            else if (prog_unaligned)
                            begin
                                status_next = ST_UNALIGNED;
                            end
                            else
                            begin
                                off_last_next = unit_last_w[AW-1:0];
                                state_next    = S_PRD;
                            end
                        end
                        OP_ERASE:
                        begin
                            if (erase_unaligned)
                            begin
                                status_next = ST_UNALIGNED;
                            end
                            else if (erase_range_bad)
                            begin
                                status_next = ST_RANGE;
                            end
                            else
                            begin
                                off_last_next = sector_last_w[AW-1:0];
                                state_next    = S_ERASE;
                            end
                        end
                        OP_ARM:
                        begin
                            eff_cmd.arm = 1'b1;
                        end
                        OP_DISARM:
                        begin
                            eff_cmd.disarm = 1'b1;
                        end
                        OP_RESTORE:
                        begin
                            eff_cmd.restore = 1'b1;
                        end
                        default:
                        begin
                            status_next = ST_OK;
                        end
                    endcase
                end
            end

            S_READ:
            begin
                rdata_next = mem_rdata;
                state_next = S_RESP;
            end

            S_PRD:
            begin
                state_next = S_PCMP;
            end

            S_PCMP:
            begin
                // A program may only clear bits of the stored byte.
                if ((mem_rdata & data_byte) != data_byte)
                begin
                    status_next = ST_TRANSITION;
                    off_next    = '0;
                    state_next  = S_RESP;
                end
                else if (off_reg == off_last_reg)
                begin
                    off_next   = '0;
                    state_next = S_PWR;
                end
                else
                begin
                    off_next   = off_reg + AW'(1);
                    state_next = S_PRD;
                end
            end

            S_PWR, S_ERASE:
            begin
                eff_cmd.persist = 1'b1;
                if (state_reg == S_ERASE)
                begin
                    mem_wdata = ERASED_BYTE;
                end
                if (eff_sts.blocked)
                begin
                    status_next = ST_POWER;
                    off_next    = '0;
                    state_next  = S_RESP;
                end
                else
                begin
                    mem_we = 1'b1;
                    if (eff_sts.last)
                    begin
                        status_next = ST_POWER;
                        off_next    = '0;
                        state_next  = S_RESP;
                    end
                    else if (off_reg == off_last_reg)
                    begin
                        off_next   = '0;
                        state_next = S_RESP;
                    end
                    else
                    begin
                        off_next = off_reg + AW'(1);
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign status    = status_reg;
    assign read_data = rdata_reg;

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe held for more than one cycle");

    a_accept_decode: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == S_DECODE))
        else $error("accepted transaction did not enter decode");

    a_blocked_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        (eff_cmd.persist && eff_sts.blocked) |-> !mem_we)
        else $error("byte written after power failure");

    a_verify_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_PRD) || (state_reg == S_PCMP)) |-> (!mem_we && !eff_cmd.persist))
        else $error("store modified during program verify");

endmodule

// ===== hw/rtl/nor_flash_model_with_power_loss_unit.sv =====
// ----------------------------------------------------------------------------
// nor_flash_model_with_power_loss_unit
// NOR flash model with byte store, geometry registers and simulated power loss.
// ----------------------------------------------------------------------------
// Each accepted command passes through decode; arm, disarm, restore, unused opcodes
// and rejected commands then raise done; a read first reads one store byte; a program
// verifies each byte of its unit, then writes each; an erase writes each sector byte.
// A new transaction is taken in the cycle that done is high; the receiver cannot stall.
// After reset a clearing pass over all MEMORY_BYTES bytes fills the store with 0xFF
// while busy is high; configuration writes are taken throughout.
// ----------------------------------------------------------------------------
module nor_flash_model_with_power_loss_unit
    import nfpl_pkg::*;
#(
    parameter int MEMORY_BYTES = MEMORY_BYTES_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  opcode,
    input  logic [16:0] address,
    input  logic [63:0] program_data,
    input  logic [31:0] fail_after_count,
    output logic        done,
    output logic [2:0]  status,
    output logic [7:0]  read_data,
    output logic        power_off,
    output logic [31:0] effect_count,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [16:0] cfg_data
);

    localparam int AW = $clog2(MEMORY_BYTES);

    logic [16:0] sector_count_reg;
    logic [4:0]  sector_log2_reg;
    logic [1:0]  unit_log2_reg;

    geo_t               geo;
    logic [TOTAL_W-1:0] total_w;
    eff_cmd_t           eff_cmd;
    eff_sts_t           eff_sts;
    logic               mem_we;
    logic [AW-1:0]      mem_addr;
    logic [7:0]         mem_wdata;
    logic [7:0]         mem_rdata;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sector_count_reg <= 17'd16;
            sector_log2_reg  <= 5'd12;
            unit_log2_reg    <= 2'd0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_SECTOR_COUNT: sector_count_reg <= cfg_data;
                CFG_SECTOR_LOG2:  sector_log2_reg  <= cfg_data[4:0];
                CFG_UNIT_LOG2:    unit_log2_reg    <= cfg_data[1:0];
                default:          sector_count_reg <= sector_count_reg;
            endcase
        end
    end

    assign total_w         = TOTAL_W'(sector_count_reg) << sector_log2_reg;
    assign geo.total       = total_w;
    assign geo.unit_log2   = unit_log2_reg;
    assign geo.sector_log2 = sector_log2_reg;
    assign geo.ok          = (sector_count_reg != 17'd0)
                          && ({3'b000, unit_log2_reg} <= sector_log2_reg)
                          && ((TOTAL_W'(1) << unit_log2_reg) <= TOTAL_W'(MAX_UNIT_BYTES))
                          && (total_w <= TOTAL_W'(MEMORY_BYTES));

    nfpl_ctrl #(
        .MEMORY_BYTES(MEMORY_BYTES)
    ) u_ctrl (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .opcode          (opcode),
        .address         (address),
        .program_data    (program_data),
        .fail_after_count(fail_after_count),
        .geo             (geo),
        .done            (done),
        .status          (status),
        .read_data       (read_data),
        .mem_we          (mem_we),
        .mem_addr        (mem_addr),
        .mem_wdata       (mem_wdata),
        .mem_rdata       (mem_rdata),
        .eff_cmd         (eff_cmd),
        .eff_sts         (eff_sts)
    );

    nfpl_byte_mem #(
        .MEMORY_BYTES(MEMORY_BYTES)
    ) u_mem (
        .clk  (clk),
        .we   (mem_we),
        .addr (mem_addr),
        .wdata(mem_wdata),
        .rdata(mem_rdata)
    );

    nfpl_effect_unit u_effect (
        .clk  (clk),
        .rst_n(rst_n),
        .cmd  (eff_cmd),
        .sts  (eff_sts)
    );

    assign power_off    = eff_sts.power_down;
    assign effect_count = eff_sts.total;

endmodule
